FILE: rtl/bpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, widths and constants for the barometric compensation block.
// ----------------------------------------------------------------------------
package bpc_pkg;

  // field widths
  localparam int RAW_W  = 24;
  localparam int CAL_W  = 16;
  localparam int TEMP_W = 21;
  localparam int PRES_W = 32;

  // default queue depths
  localparam int QUEUE_DEPTH  = 4;
  localparam int RESULT_DEPTH = 16;

  // internal datapath widths
  localparam int DT_W   = RAW_W + 1;          // signed temperature difference
  localparam int PROD_W = DT_W + CAL_W + 1;   // dT times a calibration word
  localparam int DT2_W  = 2 * DT_W;           // dT squared
  localparam int T1_W   = 20;                 // first-order temperature
  localparam int T2_W   = 19;                 // second-order temperature term
  localparam int OFF_W  = 41;                 // offset and sensitivity
  localparam int SQ_W   = 35;                 // squared temperature deltas
  localparam int CORR_W = 39;                 // second-order offset/sens terms
  localparam int LO_W   = 21;                 // low slice of sensitivity
  localparam int HI_W   = OFF_W - LO_W;       // high slice of sensitivity
  localparam int PLO_W  = RAW_W + LO_W;
  localparam int PHI_W  = RAW_W + 1 + HI_W;
  localparam int FULL_W = 66;                 // D1 times SENS
  localparam int DIFF_W = 46;                 // scaled product minus offset

  // shift amounts of the compensation formulas
  localparam int C5_SHIFT   = 8;
  localparam int C2_SHIFT   = 16;
  localparam int C1_SHIFT   = 15;
  localparam int TEMP_SHIFT = 23;
  localparam int OFF_SHIFT  = 7;
  localparam int SENS_SHIFT = 8;
  localparam int T2_SHIFT   = 31;
  localparam int P_SHIFT    = 21;
  localparam int OUT_SHIFT  = 15;

  // temperature thresholds in 0.01 C
  localparam int TEMP_REF  = 2000;
  localparam int TEMP_COLD = -1500;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_C1 = 3'd0,
    REG_C2 = 3'd1,
    REG_C3 = 3'd2,
    REG_C4 = 3'd3,
    REG_C5 = 3'd4,
    REG_C6 = 3'd5
  } cfg_reg_t;

  // calibration words
  typedef struct packed {
    logic [CAL_W-1:0] c1;
    logic [CAL_W-1:0] c2;
    logic [CAL_W-1:0] c3;
    logic [CAL_W-1:0] c4;
    logic [CAL_W-1:0] c5;
    logic [CAL_W-1:0] c6;
  } cal_t;

  // input item
  typedef struct packed {
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temperature;
  } in_item_t;

  // result item
  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_centi;
    logic signed [PRES_W-1:0] pressure_centi;
    logic                     result_valid;
  } out_item_t;

  // classified item held between front and back
  typedef struct packed {
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temperature;
    logic             ok;
  } work_item_t;

  // head of the work queue as seen by the back end
  typedef struct packed {
    logic       avail;
    work_item_t item;
  } work_head_t;

endpackage

FILE: rtl/baro_pressure_temp_compensation_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_unit
// Second-order temperature and pressure compensation of raw barometer data.
// ----------------------------------------------------------------------------
// Takes one raw pressure/temperature pair per cycle while full is low and
// returns one result per pair, in order: temperature in 0.01 C and pressure
// in 0.01 mbar, saturated to 32 bits, with result_valid low (and both values
// zero) when either raw value is zero. Sustained rate is one item per clock
// while results are popped; a pair passes the work queue and the ten pipeline
// stages into the result queue. The pipeline issues only while the result
// queue has a free slot for every item in flight, so a stalled consumer fills
// the result queue and then the work queue before full rises. The user must
// write calibration words through cfg_write/cfg_index/cfg_data while no items
// are in flight (not enforced by the block); indexes above REG_C6 are ignored.
module baro_pressure_temp_compensation_unit #(
  parameter int QUEUE_DEPTH  = bpc_pkg::QUEUE_DEPTH,
  parameter int RESULT_DEPTH = bpc_pkg::RESULT_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  bpc_pkg::in_item_t                 in_data,
  output logic                              empty,
  input  logic                              pop,
  output bpc_pkg::out_item_t                out_data,
  input  logic                              cfg_write,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bpc_pkg::CAL_W-1:0]         cfg_data
);

  import bpc_pkg::*;

  cal_t       cal;
  work_head_t head;
  logic       take;

  // calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_C1:  cal.c1 <= cfg_data;
        REG_C2:  cal.c2 <= cfg_data;
        REG_C3:  cal.c3 <= cfg_data;
        REG_C4:  cal.c4 <= cfg_data;
        REG_C5:  cal.c5 <= cfg_data;
        REG_C6:  cal.c6 <= cfg_data;
        default: cal    <= cal;
      endcase
    end
  end

  // accept and classify
  bpc_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .head    (head),
    .take    (take)
  );

  // compute and deliver
  bpc_back #(
    .RESULT_DEPTH (RESULT_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cal      (cal),
    .head     (head),
    .take     (take),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

FILE: rtl/bpc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_fifo
// Small synchronous queue with fill count, used for work and result items.
// ----------------------------------------------------------------------------
module bpc_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [WIDTH-1:0]             wdata,
  output logic                         full,
  input  logic                         pop,
  output logic [WIDTH-1:0]             rdata,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;
  logic [CW-1:0]    fill_next;
  logic             do_push;
  logic             do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // storage write
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // fill count update
  always_comb begin
    fill_next = fill;
    if (do_push && !do_pop) begin
      fill_next = fill + CW'(1);
    end else if (do_pop && !do_push) begin
      fill_next = fill - CW'(1);
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      fill <= fill_next;
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
    end
  end

  assign rdata = mem[rd_ptr];
  assign full  = (fill == CW'(DEPTH));
  assign empty = (fill == '0);
  assign count = fill;

endmodule

FILE: rtl/bpc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_front
// Accepts raw conversion pairs, flags zero readings and queues the work.
// ----------------------------------------------------------------------------
module bpc_front #(
  parameter int QUEUE_DEPTH = bpc_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  bpc_pkg::in_item_t    in_data,
  output bpc_pkg::work_head_t  head,
  input  logic                 take
);

  import bpc_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  work_item_t wr_item;
  work_item_t rd_item;
  logic       q_empty;
  logic [CW-1:0] q_count;

  // classify: a zero raw value on either channel marks the result invalid
  always_comb begin
    wr_item.raw_pressure    = in_data.raw_pressure;
    wr_item.raw_temperature = in_data.raw_temperature;
    wr_item.ok              = (|in_data.raw_pressure) && (|in_data.raw_temperature);
  end

  // work queue toward the back end
  bpc_fifo #(
    .WIDTH ($bits(work_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_work_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wr_item),
    .full  (full),
    .pop   (take),
    .rdata (rd_item),
    .empty (q_empty),
    .count (q_count)
  );

  assign head.avail = !q_empty;
  assign head.item  = rd_item;

  // work queue never holds more than its depth
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    q_count <= CW'(QUEUE_DEPTH))
    else $error("work queue count above depth");

  // full follows the fill count
  a_full_match : assert property (@(posedge clk) disable iff (rst)
    full == (q_count == CW'(QUEUE_DEPTH)))
    else $error("work queue full out of step with count");

  // head is offered exactly when the queue holds an item
  a_avail_match : assert property (@(posedge clk) disable iff (rst)
    head.avail == (q_count != '0))
    else $error("work queue head out of step with count");

endmodule

FILE: rtl/bpc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_back
// Ten-stage compensation pipeline with credit-based issue into a result queue.
// ----------------------------------------------------------------------------
module bpc_back #(
  parameter int RESULT_DEPTH = bpc_pkg::RESULT_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bpc_pkg::cal_t        cal,
  input  bpc_pkg::work_head_t  head,
  output logic                 take,
  output logic                 empty,
  input  logic                 pop,
  output bpc_pkg::out_item_t   out_data
);

  import bpc_pkg::*;

  localparam int NSTAGE = 10;
  localparam int CW     = $clog2(RESULT_DEPTH + 1);
  localparam logic signed [DIFF_W-1:0] P_MAX = DIFF_W'($signed(32'h7FFF_FFFF));
  localparam logic signed [DIFF_W-1:0] P_MIN = DIFF_W'($signed(32'h8000_0000));
  localparam logic signed [T1_W-1:0]   COLD_SPAN = T1_W'(TEMP_REF - TEMP_COLD);

  // control
  logic [NSTAGE-1:0] vld;
  logic [CW-1:0]     credit;
  logic [CW-1:0]     credit_next;
  logic              res_full;
  logic              res_push;
  logic              res_pop;
  logic [CW-1:0]     res_count;

  // stage 1
  logic [RAW_W-1:0]        d1_1;
  logic signed [DT_W-1:0]  dt_1;
  logic                    ok_1;
  // stage 2
  logic [RAW_W-1:0]          d1_2;
  logic signed [PROD_W-1:0]  pt_2;
  logic signed [PROD_W-1:0]  po_2;
  logic signed [PROD_W-1:0]  ps_2;
  logic signed [DT2_W-1:0]   dt2_2;
  logic                      ok_2;
  // stage 3
  logic [RAW_W-1:0]         d1_3;
  logic signed [T1_W-1:0]   temp1_3;
  logic signed [T1_W-1:0]   dw_3;
  logic signed [T1_W-1:0]   dc_3;
  logic [T2_W-1:0]          t2_3;
  logic signed [OFF_W-1:0]  off1_3;
  logic signed [OFF_W-1:0]  sens1_3;
  logic                     ok_3;
  // stage 4
  logic [RAW_W-1:0]         d1_4;
  logic signed [T1_W-1:0]   temp1_4;
  logic [T2_W-1:0]          t2_4;
  logic signed [OFF_W-1:0]  off1_4;
  logic signed [OFF_W-1:0]  sens1_4;
  logic [SQ_W-1:0]          sq_4;
  logic [SQ_W-1:0]          sc_4;
  logic                     cold_4;
  logic                     vcold_4;
  logic                     ok_4;
  // stage 5
  logic [RAW_W-1:0]          d1_5;
  logic signed [TEMP_W-1:0]  temp_5;
  logic signed [OFF_W-1:0]   off1_5;
  logic signed [OFF_W-1:0]   sens1_5;
  logic [CORR_W-1:0]         off2_5;
  logic [CORR_W-1:0]         sens2_5;
  logic                      ok_5;
  // stage 6
  logic [RAW_W-1:0]          d1_6;
  logic signed [TEMP_W-1:0]  temp_6;
  logic signed [OFF_W-1:0]   off_6;
  logic signed [OFF_W-1:0]   sens_6;
  logic                      ok_6;
  // stage 7
  logic signed [TEMP_W-1:0]  temp_7;
  logic signed [OFF_W-1:0]   off_7;
  logic [PLO_W-1:0]          plo_7;
  logic signed [PHI_W-1:0]   phi_7;
  logic                      ok_7;
  // stage 8
  logic signed [TEMP_W-1:0]  temp_8;
  logic signed [OFF_W-1:0]   off_8;
  logic signed [FULL_W-1:0]  full_8;
  logic                      ok_8;
  // stage 9
  logic signed [TEMP_W-1:0]  temp_9;
  logic signed [DIFF_W-1:0]  diff_9;
  logic                      ok_9;
  // stage 10
  out_item_t                 res_10;

  // combinational helpers
  logic signed [PROD_W-1:0]  pt_sh;
  logic signed [PROD_W-1:0]  po_sh;
  logic signed [PROD_W-1:0]  ps_sh;
  logic signed [DT2_W-1:0]   dt2_sh;
  logic signed [2*T1_W-1:0]  sq_full;
  logic signed [2*T1_W-1:0]  sc_full;
  logic [CORR_W-1:0]         sq5;
  logic [CORR_W-1:0]         sc7;
  logic [CORR_W-1:0]         sc11;
  logic signed [FULL_W-1:0]  full_sh;
  logic signed [DIFF_W-1:0]  p_sh;
  logic signed [PRES_W-1:0]  p_sat;

  // issue when the result queue has room for everything in flight
  assign take    = head.avail && (credit < CW'(RESULT_DEPTH));
  assign res_pop = pop && !empty;

  always_comb begin
    credit_next = credit;
    if (take && !res_pop) begin
      credit_next = credit + CW'(1);
    end else if (res_pop && !take) begin
      credit_next = credit - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      credit <= '0;
    end else begin
      vld    <= {vld[NSTAGE-2:0], take};
      credit <= credit_next;
    end
  end

  // stage shifts and products
  assign pt_sh   = pt_2 >>> TEMP_SHIFT;
  assign po_sh   = po_2 >>> OFF_SHIFT;
  assign ps_sh   = ps_2 >>> SENS_SHIFT;
  assign dt2_sh  = dt2_2 >>> T2_SHIFT;
  assign sq_full = dw_3 * dw_3;
  assign sc_full = dc_3 * dc_3;
  assign sq5     = CORR_W'(sq_4) * CORR_W'(5);
  assign sc7     = CORR_W'(sc_4) * CORR_W'(7);
  assign sc11    = CORR_W'(sc_4) * CORR_W'(11);
  assign full_sh = full_8 >>> P_SHIFT;
  assign p_sh    = diff_9 >>> OUT_SHIFT;

  // saturate pressure to 32 bits
  always_comb begin
    if (p_sh > P_MAX) begin
      p_sat = P_MAX[PRES_W-1:0];
    end else if (p_sh < P_MIN) begin
      p_sat = P_MIN[PRES_W-1:0];
    end else begin
      p_sat = p_sh[PRES_W-1:0];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // s1: temperature difference
    d1_1 <= head.item.raw_pressure;
    ok_1 <= head.item.ok;
    dt_1 <= $signed({1'b0, head.item.raw_temperature})
          - $signed(DT_W'(cal.c5) << C5_SHIFT);
    // s2: products with dT
    d1_2  <= d1_1;
    ok_2  <= ok_1;
    pt_2  <= dt_1 * $signed({1'b0, cal.c6});
    po_2  <= $signed({1'b0, cal.c4}) * dt_1;
    ps_2  <= $signed({1'b0, cal.c3}) * dt_1;
    dt2_2 <= dt_1 * dt_1;
    // s3: first-order temperature, offset and sensitivity
    d1_3    <= d1_2;
    ok_3    <= ok_2;
    dw_3    <= $signed(pt_sh[T1_W-1:0]);
    dc_3    <= $signed(pt_sh[T1_W-1:0]) + COLD_SPAN;
    temp1_3 <= $signed(pt_sh[T1_W-1:0]) + T1_W'(TEMP_REF);
    t2_3    <= dt2_sh[T2_W-1:0];
    off1_3  <= $signed(OFF_W'(cal.c2) << C2_SHIFT) + $signed(po_sh[OFF_W-1:0]);
    sens1_3 <= $signed(OFF_W'(cal.c1) << C1_SHIFT) + $signed(ps_sh[OFF_W-1:0]);
    // s4: squared deltas and cold flags
    d1_4    <= d1_3;
    ok_4    <= ok_3;
    temp1_4 <= temp1_3;
    t2_4    <= t2_3;
    off1_4  <= off1_3;
    sens1_4 <= sens1_3;
    sq_4    <= sq_full[SQ_W-1:0];
    sc_4    <= sc_full[SQ_W-1:0];
    cold_4  <= dw_3[T1_W-1];
    vcold_4 <= dc_3[T1_W-1];
    // s5: second-order terms
    d1_5    <= d1_4;
    ok_5    <= ok_4;
    off1_5  <= off1_4;
    sens1_5 <= sens1_4;
    if (cold_4) begin
      temp_5  <= TEMP_W'(temp1_4) - $signed(TEMP_W'(t2_4));
      off2_5  <= (sq5 >> 1) + (vcold_4 ? sc7 : '0);
      sens2_5 <= (sq5 >> 2) + (vcold_4 ? (sc11 >> 1) : '0);
    end else begin
      temp_5  <= TEMP_W'(temp1_4);
      off2_5  <= '0;
      sens2_5 <= '0;
    end
    // s6: corrected offset and sensitivity
    d1_6   <= d1_5;
    ok_6   <= ok_5;
    temp_6 <= temp_5;
    off_6  <= off1_5 - $signed(OFF_W'(off2_5));
    sens_6 <= sens1_5 - $signed(OFF_W'(sens2_5));
    // s7: partial products of D1 and SENS
    ok_7   <= ok_6;
    temp_7 <= temp_6;
    off_7  <= off_6;
    plo_7  <= d1_6 * sens_6[LO_W-1:0];
    phi_7  <= $signed({1'b0, d1_6}) * $signed(sens_6[OFF_W-1:LO_W]);
    // s8: full product
    ok_8   <= ok_7;
    temp_8 <= temp_7;
    off_8  <= off_7;
    full_8 <= (FULL_W'(phi_7) <<< LO_W) + $signed(FULL_W'(plo_7));
    // s9: scaled product minus offset
    ok_9   <= ok_8;
    temp_9 <= temp_8;
    diff_9 <= $signed(full_sh[DIFF_W-1:0]) - DIFF_W'(off_8);
    // s10: final shift, saturation and invalid masking
    res_10.result_valid   <= ok_9;
    res_10.temp_centi     <= ok_9 ? temp_9 : '0;
    res_10.pressure_centi <= ok_9 ? p_sat : '0;
  end

  assign res_push = vld[NSTAGE-1];

  // result queue
  bpc_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (RESULT_DEPTH)
  ) u_result_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_10),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_data),
    .empty (empty),
    .count (res_count)
  );

  // credits never exceed the result queue depth
  a_credit_bound : assert property (@(posedge clk) disable iff (rst)
    credit <= CW'(RESULT_DEPTH))
    else $error("credit count above result queue depth");

  // a finished item always finds room in the result queue
  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    !(res_push && res_full))
    else $error("result pushed into full queue");

  // credits match items in the pipeline plus items waiting in the queue
  a_credit_match : assert property (@(posedge clk) disable iff (rst)
    credit == CW'($countones(vld)) + res_count)
    else $error("credit count out of step with pipeline and queue");

endmodule
